>>> design/dtf_pkg.sv
`default_nettype none
package dtf_pkg;

   typedef enum logic [1:0] {
      OP_DOUBLE = 2'd0,
      OP_FLOAT  = 2'd1,
      OP_SINGLE = 2'd2,
      OP_OTHER  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      MODE_B32  = 3'd0,
      MODE_B16  = 3'd1,
      MODE_F8_8 = 3'd2,
      MODE_F16  = 3'd3,
      MODE_F24  = 3'd4,
      MODE_R5   = 3'd5,
      MODE_R6   = 3'd6,
      MODE_R7   = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      FMT_PASS = 3'd0,
      FMT_B32  = 3'd1,
      FMT_B16  = 3'd2,
      FMT_FX16 = 3'd3,
      FMT_FX32 = 3'd4
   } fmt_type;

   // decoded operand, stage 1 to stage 2
   typedef struct packed {
      fmt_type      fmt;
      logic         sign;
      logic         is_nan;
      logic         is_inf;
      logic         is_zero;
      logic [52:0]  sig;      // normalised, msb at bit 52
      logic signed [12:0] exp; // unbiased exponent of sig msb
      logic [4:0]   frac;
      logic [63:0]  raw;
      logic [22:0]  nan_pay;
   } dec_type;

   // shifted value, stage 2 to stage 3
   typedef struct packed {
      fmt_type      fmt;
      logic         sign;
      logic         is_nan;
      logic         is_inf;
      logic         is_zero;
      logic         ovf;      // exponent beyond range
      logic         sub;      // subnormal result region
      logic [41:0]  keep;     // integer part after shift
      logic         rbit;
      logic         sticky;
      logic [8:0]   bexp;     // biased exponent for normal results
      logic [63:0]  raw;
      logic [22:0]  nan_pay;
   } shf_type;

   localparam logic [15:0] H_QNAN = 16'h7e00;
   localparam logic [15:0] H_INF  = 16'h7c00;

endpackage
`default_nettype wire

>>> design/double_to_target_float_encoder_core.sv
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | req_source_bits, req_op
// rsp     | out       | rsp_valid/rsp_ready  | rsp_encoded_bits
// csr     | in        | csr_valid/csr_ready  | csr_short_float_mode
// Three register stages (decode/normalise, align, round/saturate).
// One item per cycle sustained while rsp is not stalled; the whole pipe advances together.
// A stalled rsp holds every stage; req_ready drops only while the last stage is held.
// Synchronous reset empties the pipe and sets the mode to binary32.
`default_nettype none
module double_to_target_float_encoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_source_bits,
   input  wire logic [1:0]  req_op,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_encoded_bits,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_short_float_mode
);
   import dtf_pkg::*;

   logic [2:0] mode_ff;
   logic       en;
   logic       v1, v2;
   dec_type    d1;
   shf_type    s2;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 3'd0;
      end else if (csr_valid) begin
         mode_ff <= csr_short_float_mode;
      end
   end

   dtf_decode u_dec (
      .clock, .reset, .en, .in_valid(req_valid), .source_bits(req_source_bits),
      .op(req_op), .mode(mode_ff), .out_valid(v1), .out_dec(d1)
   );

   dtf_shift u_shf (
      .clock, .reset, .en, .in_valid(v1), .in_dec(d1), .out_valid(v2), .out_shf(s2)
   );

   dtf_round u_rnd (
      .clock, .reset, .en, .in_valid(v2), .in_shf(s2),
      .out_valid(rsp_valid), .out_bits(rsp_encoded_bits)
   );

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_encoded_bits))
      else $error("rsp not held");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("ready while stalled");
   a_pass: assert property (@(posedge clock) disable iff (reset)
      en && v2 && s2.fmt == FMT_PASS |=> rsp_encoded_bits == $past(s2.raw))
      else $error("pass-through broken");

endmodule
`default_nettype wire

>>> design/dtf_decode.sv
`default_nettype none
module dtf_decode (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire logic [63:0]      source_bits,
   input  wire logic [1:0]       op,
   input  wire logic [2:0]       mode,
   output logic                  out_valid,
   output dtf_pkg::dec_type      out_dec
);
   import dtf_pkg::*;

   logic        valid_ff;
   dec_type     dec_ff, dec_in;
   logic [10:0] ex;
   logic [51:0] man;
   logic [52:0] sig_raw;
   logic [5:0]  lz;
   logic        found;

   always_comb begin
      ex      = source_bits[62:52];
      man     = source_bits[51:0];
      sig_raw = (ex != 11'd0) ? {1'b1, man} : {1'b0, man};
      lz      = 6'd0;
      found   = 1'b0;
      for (int i = 52; i >= 0; i--) begin
         if (!found && sig_raw[i]) begin
            found = 1'b1;
            lz    = 6'(52 - i);
         end
      end
      dec_in.sign    = source_bits[63];
      dec_in.is_nan  = (ex == 11'h7ff) && (man != 52'd0);
      dec_in.is_inf  = (ex == 11'h7ff) && (man == 52'd0);
      dec_in.is_zero = (sig_raw == 53'd0);
      dec_in.sig     = sig_raw << lz;
      dec_in.exp     = (ex != 11'd0) ? 13'($signed({2'b00, ex}) - 13'sd1023)
                                     : 13'(-13'sd1022 - $signed({7'd0, lz}));
      dec_in.raw     = source_bits;
      dec_in.nan_pay = {1'b1, man[50:29]};
      dec_in.frac    = 5'd8;
      case (op)
         OP_DOUBLE: dec_in.fmt = FMT_PASS;
         OP_FLOAT: begin
            case (mode)
               MODE_B16:  dec_in.fmt = FMT_B16;
               MODE_F8_8: dec_in.fmt = FMT_FX16;
               MODE_F16: begin
                  dec_in.fmt  = FMT_FX32;
                  dec_in.frac = 5'd16;
               end
               MODE_F24:  dec_in.fmt = FMT_FX32;
               default:   dec_in.fmt = FMT_B32;
            endcase
         end
         default: dec_in.fmt = FMT_B32;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         dec_ff <= dec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_dec   = dec_ff;

endmodule
`default_nettype wire

>>> design/dtf_shift.sv
`default_nettype none
module dtf_shift (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire dtf_pkg::dec_type in_dec,
   output logic                  out_valid,
   output dtf_pkg::shf_type      out_shf
);
   import dtf_pkg::*;

   logic        valid_ff;
   shf_type     shf_ff, shf_in;
   logic signed [13:0] pos;   // weight of sig msb relative to result lsb
   logic signed [13:0] bias_e;
   logic signed [13:0] emin;
   logic signed [13:0] emaxv;
   logic [5:0]  mb;
   logic [7:0]  rs;           // right shift of sig, msb at 52
   logic [105:0] ext;
   logic [105:0] sh;
   logic        fx;

   always_comb begin
      fx     = (in_dec.fmt == FMT_FX16) || (in_dec.fmt == FMT_FX32);
      mb     = (in_dec.fmt == FMT_B16) ? 6'd10 : 6'd23;
      bias_e = (in_dec.fmt == FMT_B16) ? 14'sd15 : 14'sd127;
      emin   = 14'sd1 - bias_e;
      emaxv  = bias_e;
      shf_in.ovf = 1'b0;
      shf_in.sub = 1'b0;
      shf_in.bexp = 9'd0;
      if (fx) begin
         pos = 14'(in_dec.exp) + 14'($signed({9'd0, in_dec.frac}));
         if (pos >= 14'sd40) shf_in.ovf = 1'b1;
      end else if (14'(in_dec.exp) >= emin) begin
         pos = 14'($signed({8'd0, mb}));
         shf_in.bexp = 9'(14'(in_dec.exp) + bias_e);
         if (14'(in_dec.exp) > emaxv) shf_in.ovf = 1'b1;
      end else begin
         shf_in.sub = 1'b1;
         pos = 14'(in_dec.exp) - emin + 14'($signed({8'd0, mb}));
      end
      if (pos > 14'sd52) begin
         rs = 8'd0;
      end else if (pos < -14'sd2) begin
         rs = 8'd55;
      end else begin
         rs = 8'(14'sd52 - pos);
      end
      ext = {in_dec.sig, 53'd0};
      sh  = ext >> rs;
      if (pos > 14'sd52) begin
         shf_in.keep   = 42'({in_dec.sig, 53'd0} >> (8'd105 - 8'(pos)));
         shf_in.rbit   = 1'b0;
         shf_in.sticky = 1'b0;
      end else begin
         shf_in.keep   = 42'(sh[105:53]);
         shf_in.rbit   = sh[52];
         shf_in.sticky = |sh[51:0];
      end
      shf_in.fmt     = in_dec.fmt;
      shf_in.sign    = in_dec.sign;
      shf_in.is_nan  = in_dec.is_nan;
      shf_in.is_inf  = in_dec.is_inf;
      shf_in.is_zero = in_dec.is_zero;
      shf_in.raw     = in_dec.raw;
      shf_in.nan_pay = in_dec.nan_pay;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         shf_ff <= shf_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_shf   = shf_ff;

endmodule
`default_nettype wire

>>> design/dtf_round.sv
`default_nettype none
module dtf_round (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire dtf_pkg::shf_type in_shf,
   output logic                  out_valid,
   output logic [63:0]           out_bits
);
   import dtf_pkg::*;

   logic        valid_ff;
   logic [63:0] bits_ff, bits_in;
   logic [41:0] q;
   logic        lsb_up;
   logic [31:0] ieee;
   logic [31:0] mag;
   logic [31:0] neg;
   logic        w;

   always_comb begin
      lsb_up = in_shf.rbit && (in_shf.sticky || in_shf.keep[0]);
      w      = (in_shf.fmt == FMT_FX32);
      ieee   = 32'd0;
      mag    = 32'd0;
      neg    = 32'd0;
      bits_in = 64'd0;
      q = in_shf.keep + 42'(lsb_up);
      case (in_shf.fmt)
         FMT_PASS: bits_in = in_shf.raw;
         FMT_B32: begin
            if (in_shf.is_nan)
               ieee = {in_shf.sign, 8'hff, in_shf.nan_pay};
            else if (in_shf.is_inf)
               ieee = {in_shf.sign, 8'hff, 23'd0};
            else if (in_shf.is_zero)
               ieee = {in_shf.sign, 31'd0};
            else if (in_shf.ovf)
               ieee = {in_shf.sign, 8'hff, 23'd0};
            else if (in_shf.sub)
               ieee = {in_shf.sign, 31'(q)};
            else
               ieee = {in_shf.sign, 31'({in_shf.bexp[7:0] - 8'd1, 23'd0} + 31'(q))};
            if (!in_shf.is_nan && ieee[30:23] == 8'hff)
               ieee[22:0] = 23'd0;
            bits_in = {32'd0, ieee};
         end
         FMT_B16: begin
            if (in_shf.is_nan)
               ieee = {16'd0, in_shf.sign, 15'(H_QNAN)};
            else if (in_shf.is_inf || in_shf.ovf)
               ieee = {16'd0, in_shf.sign, 15'(H_INF)};
            else if (in_shf.is_zero)
               ieee = {16'd0, in_shf.sign, 15'd0};
            else if (in_shf.sub)
               ieee = {16'd0, in_shf.sign, 15'(q)};
            else
               ieee = {16'd0, in_shf.sign,
                       15'({in_shf.bexp[4:0] - 5'd1, 10'd0} + 15'(q))};
            if (!in_shf.is_nan && ieee[14:10] == 5'h1f)
               ieee[9:0] = 10'd0;
            bits_in = {48'd0, ieee[15:0]};
         end
         default: begin
            if (in_shf.is_nan) begin
               bits_in = w ? 64'h7ffffffe : 64'h7ffe;
            end else if (in_shf.is_inf) begin
               if (in_shf.sign) bits_in = w ? 64'h80000000 : 64'h8000;
               else             bits_in = w ? 64'h7fffffff : 64'h7fff;
            end else if (in_shf.is_zero) begin
               bits_in = 64'd0;
            end else begin
               // half away from zero
               if (in_shf.ovf)
                  mag = 32'hffffffff;
               else if (q[41:32] != 10'd0 || in_shf.keep[41:32] != 10'd0)
                  mag = 32'hffffffff;
               else
                  mag = 32'(in_shf.keep) + 32'(in_shf.rbit);
               if (in_shf.sign) begin
                  if (w && mag > 32'h7fffffff) mag = 32'h7fffffff;
                  if (!w && mag > 32'h7fff)    mag = 32'h7fff;
                  neg = 32'd0 - mag;
                  bits_in = w ? {32'd0, neg} : {48'd0, neg[15:0]};
               end else begin
                  if (w && mag > 32'h7ffffffd) mag = 32'h7ffffffd;
                  if (!w && mag > 32'h7ffd)    mag = 32'h7ffd;
                  bits_in = {32'd0, mag};
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         bits_ff <= bits_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_bits  = bits_ff;

endmodule
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import dtf_pkg::*;

   typedef struct {
      logic [63:0] bits;
      op_type      op;
   } req_item;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   wire         req_ready;
   logic [63:0] req_source_bits = '0;
   op_type      req_op = OP_DOUBLE;
   wire         rsp_valid;
   logic        rsp_ready = 1'b0;
   wire  [63:0] rsp_encoded_bits;
   logic        csr_valid = 1'b0;
   wire         csr_ready;
   logic [2:0]  csr_short_float_mode = '0;
   logic        req_taken = 1'b0;

   double_to_target_float_encoder_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_source_bits(req_source_bits), .req_op(req_op),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_encoded_bits(rsp_encoded_bits),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_short_float_mode(csr_short_float_mode)
   );

   always #2 clock = ~clock;

   req_item     pending_q[$];
   logic [63:0] encoding_q[$];
   mode_type    tb_mode = MODE_B32;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          errors = 0;
   int          n_sent = 0;
   int          n_checked = 0;
   int          idle_cycles = 0;
   int          watchdog_limit = 5000;

   function automatic int top_bit(logic [63:0] v);
      int p;
      p = 0;
      for (int i = 0; i < 64; i++)
         if (v[i]) p = i;
      return p;
   endfunction

   function automatic logic [63:0] round_even(logic [63:0] sig, int shift);
      logic [63:0] q, rem, half;
      if (shift <= 0) return sig;
      if (shift >= 64) return 0;
      q = sig >> shift;
      rem = sig & ((64'd1 << shift) - 1);
      half = 64'd1 << (shift - 1);
      if (rem > half || (rem == half && q[0])) q++;
      return q;
   endfunction

   function automatic logic [63:0] pack_ieee(logic sign, logic [63:0] sig, int lsbexp,
                                             int ebits, int mbits);
      int          p, e, bias, shift;
      logic [63:0] emax, sbit, inf, res, q;
      p = top_bit(sig);
      e = lsbexp + p;
      bias = (1 << (ebits - 1)) - 1;
      emax = (64'd1 << ebits) - 1;
      sbit = 64'(sign) << (ebits + mbits);
      inf = sbit | (emax << mbits);
      if (e >= 1 - bias) begin
         shift = p - mbits;
         if (e + bias >= int'(emax)) return inf;
         q = (shift < 0) ? sig << (-shift) : round_even(sig, shift);
         res = (64'(e + bias - 1) << mbits) + q;
         if ((res >> mbits) >= emax) return inf;
      end else begin
         res = round_even(sig, (1 - bias - mbits) - lsbexp);
      end
      return sbit | res;
   endfunction

   function automatic logic [63:0] encode_fixed(logic sign, logic [10:0] ex, logic [51:0] man,
                                                logic [63:0] sig, int lsbexp, int frac,
                                                bit wide);
      logic [63:0] mask, maxfin, minmag, mag, q, rem;
      int          l, s;
      mask = wide ? 64'hffffffff : 64'hffff;
      maxfin = wide ? 64'h7ffffffd : 64'h7ffd;
      minmag = wide ? 64'h7fffffff : 64'h7fff;
      if (ex == 11'h7ff) begin
         if (man != 0) return wide ? 64'h7ffffffe : 64'h7ffe;
         if (sign) return wide ? 64'h80000000 : 64'h8000;
         return wide ? 64'h7fffffff : 64'h7fff;
      end
      if (sig == 0) return 0;
      l = lsbexp + frac;
      if (l >= 0) begin
         mag = (top_bit(sig) + l >= 40) ? 64'd1 << 40 : sig << l;
      end else if (-l >= 64) begin
         mag = 0;
      end else begin
         s = -l;
         q = sig >> s;
         rem = sig & ((64'd1 << s) - 1);
         if (rem >= (64'd1 << (s - 1))) q++;
         mag = q;
      end
      if (sign) begin
         if (mag > minmag) mag = minmag;
         return (64'd0 - mag) & mask;
      end
      if (mag > maxfin) mag = maxfin;
      return mag & mask;
   endfunction

   function automatic logic [63:0] encode_value(logic [63:0] bits, op_type op, mode_type mode);
      logic        sign;
      logic [10:0] ex;
      logic [51:0] man;
      logic [63:0] sig, b32;
      int          lsbexp;
      sign = bits[63];
      ex = bits[62:52];
      man = bits[51:0];
      sig = (ex != 0) ? {11'd0, 1'b1, man} : {12'd0, man};
      lsbexp = (ex != 0) ? int'(ex) - 1075 : -1074;
      if (ex == 11'h7ff)
         b32 = (man != 0) ? (64'(sign) << 31) | 64'h7fc00000 | 64'(man >> 29)
                          : (64'(sign) << 31) | 64'h7f800000;
      else if (sig == 0)
         b32 = 64'(sign) << 31;
      else
         b32 = pack_ieee(sign, sig, lsbexp, 8, 23);
      if (op == OP_DOUBLE) return bits;
      if (op != OP_FLOAT) return b32;
      case (mode)
         MODE_B16: begin
            if (ex == 11'h7ff) return (64'(sign) << 15) | ((man != 0) ? H_QNAN : H_INF);
            if (sig == 0) return 64'(sign) << 15;
            return pack_ieee(sign, sig, lsbexp, 5, 10);
         end
         MODE_F8_8: return encode_fixed(sign, ex, man, sig, lsbexp, 8, 1'b0);
         MODE_F16:  return encode_fixed(sign, ex, man, sig, lsbexp, 16, 1'b1);
         MODE_F24:  return encode_fixed(sign, ex, man, sig, lsbexp, 8, 1'b1);
         default:   return b32;
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               req_item it;
               it = pending_q.pop_front();
               req_source_bits <= it.bits;
               req_op <= it.op;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99, 0) >= stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            encoding_q.push_back(encode_value(req_source_bits, req_op, tb_mode));
            n_sent++;
         end
         if (csr_valid && csr_ready) tb_mode <= mode_type'(csr_short_float_mode);
         if (rsp_valid && rsp_ready) begin
            n_checked++;
            if (encoding_q.size() == 0)
               report_mismatch("unexpected item", rsp_encoded_bits, 64'd0);
            else if (rsp_encoded_bits !== encoding_q[0])
               report_mismatch("encoded_bits", rsp_encoded_bits, encoding_q.pop_front());
            else
               void'(encoding_q.pop_front());
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= watchdog_limit) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   function automatic logic [63:0] random_double();
      logic [63:0] b;
      int          k;
      b = {$urandom, $urandom};
      k = $urandom_range(9, 0);
      case (k)
         0: b[62:52] = 11'h7ff;
         1: b[62:52] = 11'h000;
         2: b[62:52] = 11'(1023 + $urandom_range(40, 0) - 20);
         3: b[62:52] = 11'(1023 - 126 + $urandom_range(6, 0) - 3);
         4: b[62:52] = 11'(1023 - 14 - $urandom_range(12, 0));
         5: b[62:52] = 11'(1023 + 15 + $urandom_range(2, 0) - 1);
         6: b[62:52] = 11'(1023 + 127 + $urandom_range(2, 0) - 1);
         7: begin
            b[62:52] = 11'(1023 + $urandom_range(30, 0) - 10);
            b[40:0] = '0;
            b[$urandom_range(45, 20)] = 1'b1;
         end
         default: ;
      endcase
      if ($urandom_range(7, 0) == 0) b[51:0] = '0;
      return b;
   endfunction

   task automatic queue_item(logic [63:0] b, op_type op);
      req_item it;
      it.bits = b;
      it.op = op;
      pending_q.push_back(it);
   endtask

   task automatic drain();
      while (pending_q.size() > 0 || encoding_q.size() > 0 || req_valid)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_mode(mode_type m);
      @(negedge clock);
      csr_short_float_mode <= m;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(mode_type m, int count);
      int ph;
      write_mode(m);
      for (int i = 0; i < count; i++) begin
         ph = (i * 4) / count;
         queue_item(random_double(), op_type'($urandom_range(3, 0)));
         if (i % 50 == 0) begin
            wait (pending_q.size() < 10);
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 25 : 88) : 0;
            stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 25 : 88) : 0;
         end
      end
      drain();
   endtask

   initial begin
      logic [63:0] edge_vals[$];
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      rsp_ready <= 1'b1;
      edge_vals = '{64'h0, 64'h8000000000000000, 64'h7ff0000000000000,
                    64'hfff0000000000000, 64'h7ff8000000000001, 64'hffffffffffffffff,
                    64'h0000000000000001, 64'h3ff0000000000000, 64'hbff8000000000000,
                    64'h40effc0000000000, 64'h3f10000000000000, 64'h7fefffffffffffff,
                    64'h3e70000000000000, 64'h3fe0000000000000, 64'hc0dfffc000000000,
                    64'h41dfffffff800000, 64'h3ff0000010000000, 64'h5555555555555555};
      for (int m = 0; m <= 7; m++) begin
         write_mode(mode_type'(m));
         foreach (edge_vals[i])
            queue_item(edge_vals[i], op_type'(m < 4 ? m : 1));
         drain();
      end
      for (int m = 0; m < 8; m++)
         run_phase(mode_type'(m % 5), 210);
      run_phase(MODE_R7, 80);
      run_phase(MODE_B32, 80);
      $display("sent %0d items over all short-float modes, checked %0d results",
               n_sent, n_checked);
      $display("idle and stall phases applied; %0d mismatches", errors);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
